@@ hdl/erv_pkg.sv @@
package erv_pkg;

   // Field widths
   localparam int COORD_W      = 32;   // signed Q16.16
   localparam int ANGLE_W      = 16;   // binary angle, full turn = 2^16
   localparam int ANGLE_FRAC_W = 14;   // position inside a quadrant
   localparam int SINE_W       = 15;   // unsigned Q0.15 table magnitude
   localparam int TRIG_W       = 16;   // signed Q1.15 sine / cosine

   // Sine table
   localparam int DEF_SINE_TABLE_DEPTH = 1024;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Datapath widths
   localparam int Q30_W  = 32;                 // product of two Q15 values
   localparam int Q45_W  = 48;                 // matrix entry before rounding
   localparam int MAT_W  = 18;                 // matrix entry in Q15
   localparam int XPRD_W = MAT_W + COORD_W;    // entry times coordinate
   localparam int SUM_W  = XPRD_W + 2;         // sum of three products

   // Stream packing
   localparam int REQ_DATA_W = 3 * COORD_W + 3 * ANGLE_W;   // 144 bits, 18 bytes
   localparam int RSP_DATA_W = 3 * COORD_W;                 // 96 bits, 12 bytes

   // Register stages from accepted transfer to result register
   localparam int PIPE_DEPTH = 6;

   typedef struct packed {
      logic signed [TRIG_W-1:0] sin_q15;
      logic signed [TRIG_W-1:0] cos_q15;
   } trig_pair_type;

   typedef struct packed {
      logic signed [MAT_W-1:0] m0;
      logic signed [MAT_W-1:0] m1;
      logic signed [MAT_W-1:0] m2;
      logic signed [MAT_W-1:0] m3;
      logic signed [MAT_W-1:0] m4;
      logic signed [MAT_W-1:0] m5;
      logic signed [MAT_W-1:0] m6;
      logic signed [MAT_W-1:0] m7;
      logic signed [MAT_W-1:0] m8;
   } mat_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

endpackage

@@ hdl/erv_sine_rom.sv @@
module erv_sine_rom
   import erv_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
   localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              ce,
   input  logic [ADDR_W-1:0] addr_a,
   input  logic [ADDR_W-1:0] addr_b,
   output logic [SINE_W-1:0] data_a,
   output logic [SINE_W-1:0] data_b
);

   typedef logic [SINE_W-1:0] rom_array_type [SINE_TABLE_DEPTH + 1];

   // Quarter wave, entry i = sin(i/DEPTH * pi/2), 9-term Taylor series in Q30
   function automatic rom_array_type build_table();
      rom_array_type      tab;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] e;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
         x2   = (x * x) >> 30;
         term = x;
         sum  = $signed(x);
         for (int k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k & 1) != 0) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
         e = (sum + 64'sd16384) >>> 15;
         if (e < 0) begin
            e = 64'sd0;
         end
         if (e > 64'sd32767) begin
            e = 64'sd32767;
         end
         tab[i] = e[SINE_W-1:0];
      end
      return tab;
   endfunction

   localparam rom_array_type SINE_ROM = build_table();

   logic [SINE_W-1:0] data_a_ff;
   logic [SINE_W-1:0] data_b_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         data_a_ff <= SINE_ROM[addr_a];
         data_b_ff <= SINE_ROM[addr_b];
      end
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

@@ hdl/erv_trig.sv @@
module erv_trig
   import erv_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
   input  logic               clock,
   input  logic               ce,
   input  logic [ANGLE_W-1:0] angle,
   output trig_pair_type      trig
);

   localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int PROD_W = ANGLE_FRAC_W + ADDR_W;
   localparam logic [ADDR_W-1:0] DEPTH_A = ADDR_W'(SINE_TABLE_DEPTH);

   logic [1:0]              quad;
   logic [1:0]              quad_cos;
   logic [ANGLE_FRAC_W-1:0] frac;
   logic [PROD_W-1:0]       prod;
   logic [ADDR_W-1:0]       idx;
   logic [ADDR_W-1:0]       idx_mirror;
   logic [ADDR_W-1:0]       sin_addr;
   logic [ADDR_W-1:0]       cos_addr;
   logic [SINE_W-1:0]       sin_mag;
   logic [SINE_W-1:0]       cos_mag;
   logic                    sin_neg_ff;
   logic                    cos_neg_ff;
   logic signed [TRIG_W-1:0] sin_pos;
   logic signed [TRIG_W-1:0] cos_pos;

   // cos(a) = sin(a + quarter turn): same fraction, next quadrant
   always_comb begin
      quad       = angle[ANGLE_W-1:ANGLE_FRAC_W];
      quad_cos   = quad + 2'd1;
      frac       = angle[ANGLE_FRAC_W-1:0];
      prod       = PROD_W'(frac) * PROD_W'(SINE_TABLE_DEPTH);
      idx        = prod[PROD_W-1:ANGLE_FRAC_W];
      idx_mirror = DEPTH_A - idx;
      sin_addr   = quad[0] ? idx_mirror : idx;
      cos_addr   = quad_cos[0] ? idx_mirror : idx;
   end

   erv_sine_rom #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_rom (
      .clock  (clock),
      .ce     (ce),
      .addr_a (sin_addr),
      .addr_b (cos_addr),
      .data_a (sin_mag),
      .data_b (cos_mag)
   );

   always_ff @(posedge clock) begin
      if (ce) begin
         sin_neg_ff <= quad[1];
         cos_neg_ff <= quad_cos[1];
      end
   end

   always_comb begin
      sin_pos      = $signed({1'b0, sin_mag});
      cos_pos      = $signed({1'b0, cos_mag});
      trig.sin_q15 = sin_neg_ff ? -sin_pos : sin_pos;
      trig.cos_q15 = cos_neg_ff ? -cos_pos : cos_pos;
   end

endmodule

@@ hdl/erv_matrix.sv @@
module erv_matrix
   import erv_pkg::*;
(
   input  logic          clock,
   input  logic          ce,
   input  trig_pair_type yaw,
   input  trig_pair_type pitch,
   input  trig_pair_type roll,
   output mat_type       mat
);

   // Round half up from Q45 to Q15
   function automatic logic signed [MAT_W-1:0] round30(input logic signed [Q45_W-1:0] v);
      logic signed [Q45_W-1:0] r;
      r = (v + (Q45_W'(1) <<< 29)) >>> 30;
      return r[MAT_W-1:0];
   endfunction

   logic signed [TRIG_W-1:0] ca, sa, cb, sb, cc, sc;

   // Pairwise products, Q30
   logic signed [Q30_W-1:0] ca_cb_ff, ca_sb_ff, sa_cc_ff, sa_sc_ff, sa_cb_ff;
   logic signed [Q30_W-1:0] sa_sb_ff, ca_cc_ff, ca_sc_ff, cb_sc_ff, cb_cc_ff;
   logic signed [TRIG_W-1:0] sb_ff, sc_ff, cc_ff;

   logic signed [Q45_W-1:0] v0, v1, v2, v3, v4, v5, v6, v7, v8;
   mat_type                 mat_ff;

   assign ca = yaw.cos_q15;
   assign sa = yaw.sin_q15;
   assign cb = pitch.cos_q15;
   assign sb = pitch.sin_q15;
   assign cc = roll.cos_q15;
   assign sc = roll.sin_q15;

   always_ff @(posedge clock) begin
      if (ce) begin
         ca_cb_ff <= ca * cb;
         ca_sb_ff <= ca * sb;
         sa_cc_ff <= sa * cc;
         sa_sc_ff <= sa * sc;
         sa_cb_ff <= sa * cb;
         sa_sb_ff <= sa * sb;
         ca_cc_ff <= ca * cc;
         ca_sc_ff <= ca * sc;
         cb_sc_ff <= cb * sc;
         cb_cc_ff <= cb * cc;
         sb_ff    <= sb;
         sc_ff    <= sc;
         cc_ff    <= cc;
      end
   end

   // R = Rz(yaw) * Ry(pitch) * Rx(roll), exact in Q45
   always_comb begin
      v0 = Q45_W'(ca_cb_ff) <<< 15;
      v1 = ca_sb_ff * sc_ff - (Q45_W'(sa_cc_ff) <<< 15);
      v2 = ca_sb_ff * cc_ff + (Q45_W'(sa_sc_ff) <<< 15);
      v3 = Q45_W'(sa_cb_ff) <<< 15;
      v4 = sa_sb_ff * sc_ff + (Q45_W'(ca_cc_ff) <<< 15);
      v5 = sa_sb_ff * cc_ff - (Q45_W'(ca_sc_ff) <<< 15);
      v6 = -(Q45_W'(sb_ff) <<< 30);
      v7 = Q45_W'(cb_sc_ff) <<< 15;
      v8 = Q45_W'(cb_cc_ff) <<< 15;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         mat_ff.m0 <= round30(v0);
         mat_ff.m1 <= round30(v1);
         mat_ff.m2 <= round30(v2);
         mat_ff.m3 <= round30(v3);
         mat_ff.m4 <= round30(v4);
         mat_ff.m5 <= round30(v5);
         mat_ff.m6 <= round30(v6);
         mat_ff.m7 <= round30(v7);
         mat_ff.m8 <= round30(v8);
      end
   end

   assign mat = mat_ff;

endmodule

@@ hdl/erv_apply.sv @@
module erv_apply
   import erv_pkg::*;
(
   input  logic      clock,
   input  logic      ce,
   input  point_type point_in,
   input  mat_type   mat,
   output point_type result
);

   // Round half up by 15 bits, saturate to signed 32 bits
   function automatic logic signed [COORD_W-1:0] finish(input logic signed [SUM_W-1:0] s);
      logic signed [SUM_W-1:0] r;
      logic [SUM_W-COORD_W:0]  top;
      r   = (s + (SUM_W'(1) <<< 14)) >>> 15;
      top = r[SUM_W-1:COORD_W-1];
      if (top == '0 || top == '1) begin
         return r[COORD_W-1:0];
      end else if (r[SUM_W-1]) begin
         return {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_W-1){1'b1}}};
      end
   endfunction

   // Point rides alongside the trig and matrix stages
   point_type pnt1_ff, pnt2_ff, pnt3_ff;

   logic signed [XPRD_W-1:0] prd_ff [9];
   logic signed [SUM_W-1:0]  sum_x_ff, sum_y_ff, sum_z_ff;
   point_type                result_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         pnt1_ff <= point_in;
         pnt2_ff <= pnt1_ff;
         pnt3_ff <= pnt2_ff;

         prd_ff[0] <= mat.m0 * pnt3_ff.x;
         prd_ff[1] <= mat.m1 * pnt3_ff.y;
         prd_ff[2] <= mat.m2 * pnt3_ff.z;
         prd_ff[3] <= mat.m3 * pnt3_ff.x;
         prd_ff[4] <= mat.m4 * pnt3_ff.y;
         prd_ff[5] <= mat.m5 * pnt3_ff.z;
         prd_ff[6] <= mat.m6 * pnt3_ff.x;
         prd_ff[7] <= mat.m7 * pnt3_ff.y;
         prd_ff[8] <= mat.m8 * pnt3_ff.z;

         sum_x_ff <= SUM_W'(prd_ff[0]) + SUM_W'(prd_ff[1]) + SUM_W'(prd_ff[2]);
         sum_y_ff <= SUM_W'(prd_ff[3]) + SUM_W'(prd_ff[4]) + SUM_W'(prd_ff[5]);
         sum_z_ff <= SUM_W'(prd_ff[6]) + SUM_W'(prd_ff[7]) + SUM_W'(prd_ff[8]);

         result_ff.x <= finish(sum_x_ff);
         result_ff.y <= finish(sum_y_ff);
         result_ff.z <= finish(sum_z_ff);
      end
   end

   assign result = result_ff;

endmodule

@@ hdl/euler_rotate_vector.sv @@
// Rotates a 3D point (signed Q16.16) by yaw, pitch and roll in Z-Y-X order:
// out = Rz(yaw) * Ry(pitch) * Rx(roll) * point. Angles are 16-bit binary
// angles, 65536 = one full turn. Sine and cosine come from a quarter-wave
// Q0.15 ROM of SINE_TABLE_DEPTH+1 entries (one ROM copy per angle, each read
// for sine and cosine in the same cycle). Matrix entries are rounded half up
// to Q15; each output is rounded half up to Q16.16 and saturated to 32 bits.
// Throughput is one transfer per clock while the result register is empty
// or being taken. The pipeline has 6 register stages: ROM read, pairwise
// angle products, matrix entries, entry-by-coordinate products, row sums,
// round/saturate. The first stage loads at the edge that accepts the req
// transfer. There is exactly one rsp transfer per req transfer. The
// pipeline advances as a whole whenever the result register is empty or
// being taken, so req_tready follows rsp_tready combinationally. No
// configuration registers, no startup delay.

module euler_rotate_vector
   import erv_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH   // 64 .. 16384
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // point_x[31:0], point_y[63:32], point_z[95:64],
   // pitch_angle[111:96], yaw_angle[127:112], roll_angle[143:128]
   input  logic [REQ_DATA_W-1:0] req_tdata,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_x[31:0], out_y[63:32], out_z[95:64]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Whole-pipeline advance: result register empty or drained this cycle
   logic                  ce;
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic [PIPE_DEPTH-1:0] vld_in;

   point_type            point_in;
   logic [ANGLE_W-1:0]   pitch_angle;
   logic [ANGLE_W-1:0]   yaw_angle;
   logic [ANGLE_W-1:0]   roll_angle;

   trig_pair_type yaw_trig;
   trig_pair_type pitch_trig;
   trig_pair_type roll_trig;
   mat_type       mat;
   point_type     result;

   assign ce         = !vld_ff[PIPE_DEPTH-1] || rsp_tready;
   assign req_tready = ce;
   assign rsp_tvalid = vld_ff[PIPE_DEPTH-1];

   // Unpack the request
   always_comb begin
      point_in.x  = req_tdata[COORD_W-1:0];
      point_in.y  = req_tdata[2*COORD_W-1:COORD_W];
      point_in.z  = req_tdata[3*COORD_W-1:2*COORD_W];
      pitch_angle = req_tdata[3*COORD_W+ANGLE_W-1:3*COORD_W];
      yaw_angle   = req_tdata[3*COORD_W+2*ANGLE_W-1:3*COORD_W+ANGLE_W];
      roll_angle  = req_tdata[3*COORD_W+3*ANGLE_W-1:3*COORD_W+2*ANGLE_W];
   end

   // Valid bits travel with the data, one per stage
   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: sine / cosine lookups
   erv_trig #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_trig_yaw (
      .clock (clock),
      .ce    (ce),
      .angle (yaw_angle),
      .trig  (yaw_trig)
   );

   erv_trig #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_trig_pitch (
      .clock (clock),
      .ce    (ce),
      .angle (pitch_angle),
      .trig  (pitch_trig)
   );

   erv_trig #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_trig_roll (
      .clock (clock),
      .ce    (ce),
      .angle (roll_angle),
      .trig  (roll_trig)
   );

   // Stages 2-3: rotation matrix
   erv_matrix u_matrix (
      .clock (clock),
      .ce    (ce),
      .yaw   (yaw_trig),
      .pitch (pitch_trig),
      .roll  (roll_trig),
      .mat   (mat)
   );

   // Stages 4-6: matrix times point, round, saturate
   erv_apply u_apply (
      .clock    (clock),
      .ce       (ce),
      .point_in (point_in),
      .mat      (mat),
      .result   (result)
   );

   assign rsp_tdata = {result.z, result.y, result.x};

endmodule
